[design/lef_pkg.sv]
// ----------------------------------------------------------------------------
// lef_pkg
// shared types, constants, the mirrored walk step and the log2 table function of the entropy filter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package lef_pkg;

  localparam int DEF_MAX_WIDTH   = 64;
  localparam int DEF_MAX_HEIGHT  = 64;
  localparam int DEF_MAX_RADIUS  = 4;
  localparam int DEF_GRAY_LEVELS = 256;

  localparam int DIM_W = 11;
  localparam int RAD_W = 3;
  localparam int OUT_W = 16;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP,
    ST_RD_IMG,
    ST_RD_HIST,
    ST_WR_HIST,
    ST_SUM,
    ST_DRAIN,
    ST_FIN,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [DIM_W-1:0] pos;
    logic             down;
  } walk_t;

  // one step of a mirrored coordinate walk with edge repeat
  function automatic walk_t walk_step(walk_t s, logic [DIM_W-1:0] size);
    walk_t n;
    n = s;
    if (s.down) begin
      if (s.pos == '0) n.down = 1'b0;
      else n.pos = s.pos - 1'b1;
    end else begin
      if (s.pos == size - 1'b1) n.down = 1'b1;
      else n.pos = s.pos + 1'b1;
    end
    return n;
  endfunction

  // log2 in q16, truncated, by repeated squaring of a q30 mantissa
  function automatic logic [31:0] log2_q16(int unsigned h);
    int unsigned k;
    logic [63:0] x;
    logic [31:0] res;
    k = 0;
    res = '0;
    if (h != 0) begin
      while (k < 31 && (h >> (k + 1)) != 0) k++;
      x = (64'(h) << 30) >> k;
      res = 32'(k) << 16;
      for (int b = 15; b >= 0; b--) begin
        x = (x * x) >> 30;
        if (x >= (64'd1 << 31)) begin
          x = x >> 1;
          res[b] = 1'b1;
        end
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

[design/local_entropy_filter_core.sv]
// ----------------------------------------------------------------------------
// local_entropy_filter_core
// image store with windowed shannon entropy queries
// ----------------------------------------------------------------------------
// start/busy command channel: a word is taken when start is high and busy low.
// command write stores pixel at (col,row) and gives no result.
// command query returns one word on done for exactly one cycle: the entropy
// of the mirrored window around (col,row), unsigned q4.12, or out_of_range.
// an out-of-range query answers the cycle after it is taken.
// an in-range query walks to the window corner in ST_PREP, then reads each
// window pixel and updates its histogram bin (ST_RD_IMG, ST_RD_HIST,
// ST_WR_HIST), makes a summing pass over every histogram bin, and runs a
// serial divider that produces one quotient bit per cycle.
// after reset the histogram ram is cleared bin by bin with busy high.
// the apb port is to take register writes only while the block is idle; the block itself does not enforce this.
// results cannot be stalled; the receiver takes each word as it appears.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module local_entropy_filter_core import lef_pkg::*; #(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS  = DEF_MAX_RADIUS,
  parameter int GRAY_LEVELS = DEF_GRAY_LEVELS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        command,
  input  wire logic [5:0]  col,
  input  wire logic [5:0]  row,
  input  wire logic [7:0]  pixel,
  output logic             done,
  output logic [15:0]      entropy_value,
  output logic             out_of_range,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int IMG_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int IMG_AW    = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
  localparam int LVL_W     = $clog2(GRAY_LEVELS);
  localparam int N_MAX     = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int CNT_W     = $clog2(N_MAX + 1);
  localparam int TAB_N     = 2 ** CNT_W;
  localparam int LOG_W     = CNT_W + 16;
  localparam int ACC_W     = CNT_W + LOG_W;
  localparam int NUM_W     = ACC_W + 1;
  localparam int DEN_W     = CNT_W + 4;
  localparam int DC_W      = $clog2(NUM_W + 1);

  state_t state, state_next;

  logic [6:0]       image_width, image_height;
  logic [2:0]       window_radius;
  logic [DIM_W-1:0] w_eff, h_eff;
  logic [RAD_W-1:0] r_eff;
  logic             cfg_wr, query_oor;

  logic             img_we;
  logic [IMG_AW-1:0] img_waddr, img_raddr;
  logic [7:0]       img_wdata, img_rdata;
  logic             hist_we;
  logic [LVL_W-1:0] hist_waddr, hist_raddr;
  logic [CNT_W-1:0] hist_wdata, hist_rdata;

  logic [LOG_W-1:0] log_tab [TAB_N];

  walk_t            xw, yw, xs;
  logic [RAD_W-1:0] step_cnt;
  logic [RAD_W:0]   side, ix, iy;
  logic [CNT_W-1:0] n_reg;
  logic [LVL_W-1:0] bin, bin_r;
  logic [LVL_W:0]   clr_cnt;
  logic             v1, v2;
  logic [ACC_W-1:0] prod, acc, total;
  logic [NUM_W-1:0] quo;
  logic [DEN_W:0]   rem, rem_sh;
  logic [DEN_W-1:0] den;
  logic [DC_W-1:0]  div_cnt;
  logic [1:0]       drain_cnt;
  logic [ACC_W-1:0] diff;

  for (genvar g = 0; g < TAB_N; g++) begin : g_log
    assign log_tab[g] = LOG_W'(log2_q16(g));
  end

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= 7'd64;
      image_height  <= 7'd64;
      window_radius <= 3'd4;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_WIDTH:  image_width   <= pwdata[6:0];
        REG_HEIGHT: image_height  <= pwdata[6:0];
        REG_RADIUS: window_radius <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WIDTH:  prdata = {25'd0, image_width};
      REG_HEIGHT: prdata = {25'd0, image_height};
      REG_RADIUS: prdata = {29'd0, window_radius};
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    if (image_width == '0) w_eff = DIM_W'(1);
    else if (int'(image_width) > MAX_WIDTH) w_eff = DIM_W'(MAX_WIDTH);
    else w_eff = DIM_W'(image_width);
    if (image_height == '0) h_eff = DIM_W'(1);
    else if (int'(image_height) > MAX_HEIGHT) h_eff = DIM_W'(MAX_HEIGHT);
    else h_eff = DIM_W'(image_height);
    if (int'(window_radius) > MAX_RADIUS) r_eff = RAD_W'(MAX_RADIUS);
    else r_eff = window_radius;
  end

  assign query_oor = (DIM_W'(col) >= w_eff) || (DIM_W'(row) >= h_eff);

  // memories
  lef_ram #(.WIDTH(8), .DEPTH(IMG_DEPTH), .AW(IMG_AW)) u_img (
    .clk   (clk),
    .we    (img_we),
    .waddr (img_waddr),
    .wdata (img_wdata),
    .raddr (img_raddr),
    .rdata (img_rdata)
  );

  lef_ram #(.WIDTH(CNT_W), .DEPTH(GRAY_LEVELS), .AW(LVL_W)) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  assign img_we    = (state == ST_IDLE) && start && (command == CMD_WRITE) &&
                     (int'(col) < MAX_WIDTH) && (int'(row) < MAX_HEIGHT);
  assign img_waddr = IMG_AW'(int'(row) * MAX_WIDTH + int'(col));
  assign img_wdata = (int'(pixel) >= GRAY_LEVELS) ? 8'(GRAY_LEVELS - 1) : pixel;
  assign img_raddr = IMG_AW'(int'(yw.pos) * MAX_WIDTH + int'(xw.pos));

  assign busy = (state != ST_IDLE);
  assign diff = (total > acc) ? total - acc : '0;
  assign rem_sh = {rem[DEN_W-1:0], quo[NUM_W-1]};

  // state machine
  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    hist_we    = 1'b0;
    hist_waddr = bin_r;
    hist_wdata = '0;
    hist_raddr = bin;
    unique case (state)
      ST_CLEAR: begin
        hist_we    = 1'b1;
        hist_waddr = clr_cnt[LVL_W-1:0];
        if (clr_cnt == (LVL_W+1)'(GRAY_LEVELS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start && command == CMD_QUERY && !query_oor) state_next = ST_PREP;
      end
      ST_PREP: begin
        if (step_cnt == '0) state_next = ST_RD_IMG;
      end
      ST_RD_IMG:  state_next = ST_RD_HIST;
      ST_RD_HIST: begin
        hist_raddr = img_rdata[LVL_W-1:0];
        state_next = ST_WR_HIST;
      end
      ST_WR_HIST: begin
        hist_we    = 1'b1;
        hist_wdata = hist_rdata + 1'b1;
        if (ix == side - 1'b1 && iy == side - 1'b1) state_next = ST_SUM;
        else state_next = ST_RD_IMG;
      end
      ST_SUM: begin
        hist_we    = 1'b1;
        hist_waddr = bin;
        if (bin == LVL_W'(GRAY_LEVELS - 1)) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (drain_cnt == 2'd1) state_next = ST_FIN;
      end
      ST_FIN: state_next = ST_DIV;
      ST_DIV: begin
        if (div_cnt == DC_W'(1)) state_next = ST_DONE;
      end
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    done <= 1'b0;
    v1   <= (state == ST_SUM);
    v2   <= v1;
    prod <= ACC_W'(hist_rdata) * ACC_W'(log_tab[hist_rdata]);
    if (v2) acc <= acc + prod;
    unique case (state)
      ST_CLEAR: clr_cnt <= clr_cnt + 1'b1;
      ST_IDLE: begin
        if (start && command == CMD_QUERY) begin
          if (query_oor) begin
            done          <= 1'b1;
            out_of_range  <= 1'b1;
            entropy_value <= '0;
          end
          xw       <= '{pos: DIM_W'(col), down: 1'b1};
          yw       <= '{pos: DIM_W'(row), down: 1'b1};
          step_cnt <= r_eff;
          side     <= {r_eff, 1'b1};
          ix       <= '0;
          iy       <= '0;
          acc      <= '0;
        end
      end
      ST_PREP: begin
        n_reg <= CNT_W'(side) * CNT_W'(side);
        if (step_cnt == '0) begin
          xw.down <= !xw.down;
          yw.down <= !yw.down;
          xs      <= '{pos: xw.pos, down: !xw.down};
        end else begin
          xw       <= walk_step(xw, w_eff);
          yw       <= walk_step(yw, h_eff);
          step_cnt <= step_cnt - 1'b1;
        end
      end
      ST_RD_HIST: bin_r <= img_rdata[LVL_W-1:0];
      ST_WR_HIST: begin
        bin   <= '0;
        total <= ACC_W'(n_reg) * ACC_W'(log_tab[n_reg]);
        if (ix == side - 1'b1) begin
          ix <= '0;
          xw <= xs;
          iy <= iy + 1'b1;
          yw <= walk_step(yw, h_eff);
        end else begin
          ix <= ix + 1'b1;
          xw <= walk_step(xw, w_eff);
        end
      end
      ST_SUM: begin
        bin       <= bin + 1'b1;
        drain_cnt <= 2'd2;
      end
      ST_DRAIN: drain_cnt <= drain_cnt - 1'b1;
      ST_FIN: begin
        quo     <= NUM_W'(diff) + NUM_W'({n_reg, 3'b000});
        den     <= {n_reg, 4'b0000};
        rem     <= '0;
        div_cnt <= DC_W'(NUM_W);
      end
      ST_DIV: begin
        div_cnt <= div_cnt - 1'b1;
        if (rem_sh >= {1'b0, den}) begin
          rem <= rem_sh - {1'b0, den};
          quo <= {quo[NUM_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[NUM_W-2:0], 1'b0};
        end
      end
      ST_DONE: begin
        done          <= 1'b1;
        out_of_range  <= 1'b0;
        entropy_value <= quo[OUT_W-1:0];
      end
      default: ;
    endcase
    if (rst) begin
      done    <= 1'b0;
      clr_cnt <= '0;
      v1      <= 1'b0;
      v2      <= 1'b0;
    end
  end

  // checks
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result word while busy");

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (done && out_of_range) |-> (entropy_value == '0))
    else $error("out of range word carries entropy");

  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (entropy_value <= 16'd32768)) else $error("entropy above 8 bits");

  a_clear: assert property (@(posedge clk)
    rst |=> busy) else $error("not busy after reset");

endmodule
`default_nettype wire

[design/lef_ram.sv]
// ----------------------------------------------------------------------------
// lef_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lef_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first on address collision
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[test/tb_local_entropy_filter_core.sv]
// ----------------------------------------------------------------------------
// tb_local_entropy_filter_core
// self-checking bench: pixel writes and entropy queries over apb-set sizes
// ----------------------------------------------------------------------------
// an image is loaded, then queries are sent; every result word is checked
// against an in-bench copy of the store and a q16 log2 entropy predictor.
// the directed part covers extremes, radius 0, a one-pixel image, a flat
// window and queries outside the image. later phases set narrow and
// random sizes and mix writes with queries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_local_entropy_filter_core;
  import lef_pkg::*;

  localparam int WATCHDOG = 20000;

  typedef struct {
    logic       cmd;
    logic [5:0] c;
    logic [5:0] r;
    logic [7:0] p;
    logic       known;
    logic [15:0] ent;
    logic        oor;
  } stim_row_t;

  typedef struct {
    logic [15:0] ent;
    logic        oor;
  } entropy_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic command = 1'b0;
  logic [5:0] col = '0;
  logic [5:0] row = '0;
  logic [7:0] pixel = '0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic busy, done, out_of_range, pready;
  logic [15:0] entropy_value;
  logic [31:0] prdata;

  logic [7:0] shadow_img [64*64];
  bit shadow_valid [64*64];
  int cfg_w = 64, cfg_h = 64, cfg_r = 4;
  entropy_word_t pending_words [$];
  int errors = 0;
  int idle_cycles = 0;
  bit no_gaps = 1'b0;

  always #4 clk = ~clk;

  local_entropy_filter_core DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .col(col), .row(row), .pixel(pixel), .done(done),
    .entropy_value(entropy_value), .out_of_range(out_of_range),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  function automatic longint unsigned q16_log2(int unsigned h);
    int unsigned k;
    longint unsigned x, res;
    k = 0;
    res = 0;
    if (h != 0) begin
      while (k < 31 && (h >> (k + 1)) != 0) k++;
      x = (64'(h) << 30) >> k;
      res = 64'(k) << 16;
      for (int b = 15; b >= 0; b--) begin
        x = (x * x) >> 30;
        if (x >= (64'd1 << 31)) begin
          x = x >> 1;
          res = res | (64'd1 << b);
        end
      end
    end
    return res;
  endfunction

  function automatic int fold_index(int t, int size);
    int p, m;
    p = 2 * size;
    m = t % p;
    if (m < 0) m += p;
    if (m >= size) m = p - 1 - m;
    return m;
  endfunction

  function automatic entropy_word_t window_entropy(int c, int r);
    entropy_word_t w;
    int hist [256];
    int n, y, x;
    longint unsigned s, total, d;
    w.ent = '0;
    w.oor = 1'b0;
    if (c >= cfg_w || r >= cfg_h) begin
      w.oor = 1'b1;
      return w;
    end
    foreach (hist[i]) hist[i] = 0;
    for (int dy = -cfg_r; dy <= cfg_r; dy++) begin
      y = fold_index(r + dy, cfg_h);
      for (int dx = -cfg_r; dx <= cfg_r; dx++) begin
        x = fold_index(c + dx, cfg_w);
        hist[shadow_img[y*64+x]]++;
      end
    end
    n = (2*cfg_r+1) * (2*cfg_r+1);
    s = 0;
    foreach (hist[i]) if (hist[i] != 0) s += 64'(hist[i]) * q16_log2(hist[i]);
    total = 64'(n) * q16_log2(n);
    d = total > s ? total - s : 0;
    w.ent = 16'((d + 8*n) / (16*n));
    return w;
  endfunction

  function automatic bit window_written(int c, int r);
    if (c >= cfg_w || r >= cfg_h) return 1'b1;
    for (int dy = -cfg_r; dy <= cfg_r; dy++)
      for (int dx = -cfg_r; dx <= cfg_r; dx++)
        if (!shadow_valid[fold_index(r+dy, cfg_h)*64 + fold_index(c+dx, cfg_w)])
          return 1'b0;
    return 1'b1;
  endfunction

  task automatic apb_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic set_geometry(int w, int h, int r);
    @(negedge clk);
    start <= 1'b0;
    wait (pending_words.size() == 0);
    repeat (600) @(posedge clk);
    apb_write(REG_WIDTH, w);
    apb_write(REG_HEIGHT, h);
    apb_write(REG_RADIUS, r);
    cfg_w = (w == 0) ? 1 : (w > 64 ? 64 : w);
    cfg_h = (h == 0) ? 1 : (h > 64 ? 64 : h);
    cfg_r = r > 4 ? 4 : r;
  endtask

  task automatic send_word(logic cmd, logic [5:0] c, logic [5:0] r, logic [7:0] p);
    if (!no_gaps && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(1, 13) - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1; command <= cmd; col <= c; row <= r; pixel <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (cmd == CMD_WRITE) begin
      shadow_img[r*64+c] = p;
      shadow_valid[r*64+c] = 1'b1;
    end else begin
      pending_words.push_back(window_entropy(c, r));
    end
  endtask

  always @(posedge clk) begin
    entropy_word_t w;
    if (!rst) begin
      idle_cycles <= (done || (start && !busy) || psel) ? 0 : idle_cycles + 1;
      if (done) begin
        if (pending_words.size() == 0) begin
          $error("unexpected word: entropy_value %0d", entropy_value);
          errors++;
        end else begin
          w = pending_words.pop_front();
          if (entropy_value !== w.ent) begin
            $error("entropy_value expected %0d actual %0d", w.ent, entropy_value);
            errors++;
          end
          if (out_of_range !== w.oor) begin
            $error("out_of_range expected %0b actual %0b", w.oor, out_of_range);
            errors++;
          end
        end
      end
      if (idle_cycles >= WATCHDOG) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  stim_row_t directed [$];

  task automatic add_row(logic cmd, int c, int r, int p, logic known = 0,
                         int ent = 0, logic oor = 0);
    stim_row_t s;
    s.cmd = cmd; s.c = 6'(c); s.r = 6'(r); s.p = 8'(p);
    s.known = known; s.ent = 16'(ent); s.oor = oor;
    directed.push_back(s);
  endtask

  task automatic fill_region(int x0, int y0, int w, int h, bit rand_fill);
    for (int y = y0; y < y0 + h; y++)
      for (int x = x0; x < x0 + w; x++)
        send_word(CMD_WRITE, 6'(x), 6'(y), rand_fill ? 8'($urandom_range(0, 255)) : 8'd0);
  endtask

  initial begin
    int w, h, r, c, q;
    entropy_word_t chk;
    foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // tiny image for the directed part
    set_geometry(4, 4, 4);
    fill_region(0, 0, 4, 4, 0);
    add_row(CMD_QUERY, 0, 0, 0, 1, 0, 0);
    add_row(CMD_QUERY, 4, 0, 0, 1, 0, 1);
    add_row(CMD_QUERY, 0, 4, 0, 1, 0, 1);
    add_row(CMD_QUERY, 63, 63, 255, 1, 0, 1);
    add_row(CMD_WRITE, 0, 0, 255);
    add_row(CMD_WRITE, 3, 3, 254);
    add_row(CMD_WRITE, 1, 2, 8'hAA);
    add_row(CMD_WRITE, 2, 1, 8'h55);
    add_row(CMD_WRITE, 63, 63, 255);
    add_row(CMD_QUERY, 0, 0, 0);
    add_row(CMD_QUERY, 3, 3, 0);
    add_row(CMD_QUERY, 1, 2, 0);
    foreach (directed[i]) begin
      send_word(directed[i].cmd, directed[i].c, directed[i].r, directed[i].p);
      if (directed[i].known && directed[i].cmd == CMD_QUERY) begin
        chk = pending_words[$];
        if (chk.ent !== directed[i].ent || chk.oor !== directed[i].oor) begin
          $error("table row %0d disagrees with predictor", i);
          errors++;
        end
      end
    end

    // radius 0, one-pixel image, register extremes out of range
    set_geometry(0, 0, 0);
    send_word(CMD_QUERY, 0, 0, 0);
    send_word(CMD_QUERY, 1, 0, 0);
    set_geometry(1, 1, 7);
    send_word(CMD_QUERY, 0, 0, 0);
    set_geometry(127, 127, 4);
    fill_region(0, 0, 16, 16, 1);
    fill_region(59, 59, 5, 5, 1);
    send_word(CMD_QUERY, 0, 0, 0);
    send_word(CMD_QUERY, 63, 63, 0);
    send_word(CMD_QUERY, 8, 8, 0);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin w = 64; h = 64; r = 4; end
        1: begin w = 1; h = 64; r = 4; end
        2: begin w = 64; h = 1; r = 3; end
        3: begin w = 2; h = 3; r = 4; end
        default: begin
          w = $urandom_range(1, 64); h = $urandom_range(1, 64); r = $urandom_range(0, 7);
        end
      endcase
      set_geometry(w, h, r);
      no_gaps = (ph == 7);
      q = 0;
      while (q < 85) begin
        c = $urandom_range(0, 15);
        r = $urandom_range(0, 15);
        if ($urandom_range(0, 2) == 0) begin
          if ($urandom_range(0, 3) == 0) begin
            c = $urandom_range(0, 63);
            r = $urandom_range(0, 63);
          end
          send_word(CMD_WRITE, 6'(c), 6'(r), $urandom_range(0, 3) == 0 ?
                    ($urandom_range(0, 1) ? 8'hFF : 8'h00) : 8'($urandom_range(0, 255)));
        end else begin
          if ($urandom_range(0, 9) != 0) begin
            c = $urandom_range(0, (cfg_w < 16 ? cfg_w : 16) - 1);
            r = $urandom_range(0, (cfg_h < 16 ? cfg_h : 16) - 1);
          end else begin
            c = $urandom_range(0, 63);
            r = $urandom_range(0, 63);
          end
          if (window_written(c, r))
            send_word(CMD_QUERY, 6'(c), 6'(r), 8'($urandom_range(0, 255)));
        end
        q++;
      end
    end

    @(negedge clk);
    start <= 1'b0;
    wait (pending_words.size() == 0);
    repeat (600) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[local_entropy_filter_core.f]
design/lef_pkg.sv
design/lef_ram.sv
design/local_entropy_filter_core.sv
test/tb_local_entropy_filter_core.sv
